>>> sv/lbp_3x3_pixel_stream_assert.svh
// Assertion macros for the LBP 3x3 pixel stream checker
`ifndef LBP_3X3_PIXEL_STREAM_ASSERT_SVH
`define LBP_3X3_PIXEL_STREAM_ASSERT_SVH

// same-cycle implication, off while reset is high
`define LBP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbp_3x3_pixel_stream: assertion failed");

// next-cycle implication, off while reset is high
`define LBP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbp_3x3_pixel_stream: assertion failed");

// next-cycle implication that also spans reset
`define LBP_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lbp_3x3_pixel_stream: assertion failed");

`endif

>>> sv/lbp_pkg.sv
// Shared types and constants for the LBP 3x3 pixel stream
package lbp_pkg;

   localparam int PIXEL_W    = 8;
   localparam int CODE_W     = 8;
   localparam int POS_W      = 11;
   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 1;

   // frame size limits and reset sizes
   localparam int SIZE_MIN   = 3;
   localparam int HEIGHT_MAX = 2048;
   localparam int WIDTH_RST  = 640;
   localparam int HEIGHT_RST = 480;

   // code bit positions, clockwise from upper left
   localparam int BIT_UL = 7;
   localparam int BIT_U  = 6;
   localparam int BIT_UR = 5;
   localparam int BIT_R  = 4;
   localparam int BIT_LR = 3;
   localparam int BIT_D  = 2;
   localparam int BIT_LL = 1;
   localparam int BIT_L  = 0;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [CSR_W-1:0]   csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

endpackage

>>> sv/lbp_stream_ifs.sv
// Valid/ready stream interfaces for pixel requests and code responses
interface lbp_req_if;
   import lbp_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_rsp_if;
   import lbp_pkg::*;

   logic     valid;
   logic     ready;
   code_type lbp_code;
   pos_type  center_col;
   pos_type  center_row;
   logic     frame_last;

   modport source (output valid, output lbp_code, output center_col, output center_row,
                   output frame_last, input ready);
   modport sink   (input valid, input lbp_code, input center_col, input center_row,
                   input frame_last, output ready);
endinterface

>>> sv/lbp_ram.sv
// Generic simple dual-port RAM with registered read
module lbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lbp_3x3_pixel_stream.sv
// 3x3 local binary pattern over a raster pixel stream
//
// req_bus carries one grey pixel per word in raster order; rsp_bus returns
// one word per interior centre pixel: the 8-bit code, the centre column and
// row, and frame_last on the final interior code of the frame. Border pixels
// (first two rows and columns of the lower-right corner) produce no word.
// csr_* writes frame width (index 0) and height (index 1); values are
// clamped to 3..MAX_WIDTH and 3..2048. Write them only while idle.
//
// Throughput: one pixel word per cycle, set by the line store RAM, which
// is read at the accept edge and written back as the word leaves the read
// stage, always at another column. The completing pixel is registered in
// stage 1 and its code word then in the output register once it is free.
// When rsp_bus stalls, the output register and one pixel in flight are held
// and req_bus.ready drops until the output word is taken.
// Reset (synchronous) clears counters, window and handshake state and loads
// 640 x 480. Line store contents are not cleared; every entry that feeds a
// code is written earlier in the frame.
module lbp_3x3_pixel_stream #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   lbp_req_if.sink                     req_bus,
   lbp_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  lbp_pkg::csr_index_type      csr_index,
   input  lbp_pkg::csr_data_type       csr_wr_data
);
   import lbp_pkg::*;

   localparam int CB = $clog2(MAX_WIDTH);          // column index bits
   localparam int WB = CB + 1;                     // width value bits
   localparam int SB = (WB > CSR_W) ? WB : CSR_W;  // clamp compare bits
   localparam int HB = CSR_W;                      // height value bits
   localparam logic [WB-1:0] W_MAX = WB'(MAX_WIDTH);
   localparam logic [WB-1:0] W_RST = (WIDTH_RST > MAX_WIDTH) ? W_MAX : WB'(WIDTH_RST);
   localparam logic [HB-1:0] H_RST = HB'(HEIGHT_RST);
   localparam int MW = 2 * PIXEL_W;                // line store word: {upper, middle}

   // configuration
   logic [WB-1:0]    frame_w_ff, frame_w_in;
   logic [HB-1:0]    frame_h_ff, frame_h_in;
   logic [SB-1:0]    csr_wide;

   // position counters
   logic [CB-1:0]    col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic             wrap_pre;
   logic [CB-1:0]    col_cur;
   logic [POS_W:0]   row_pre;
   logic [POS_W-1:0] row_cur;
   logic [WB-1:0]    col_inc;
   logic [POS_W:0]   row_inc;

   // stage 1: line store read in flight
   logic             s1_valid_ff, s1_valid_in;
   pixel_type        s1_pixel_ff;
   logic [CB-1:0]    s1_col_ff;
   logic [POS_W-1:0] s1_row_ff;
   logic             s1_interior_ff, s1_last_ff;
   logic             s1_adv;

   // window and code
   pixel_type        win_ff [9];
   pixel_type        win_in [9];
   code_type         code;
   pixel_type        up_px, mid_px;
   logic [MW-1:0]    rd_data;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   code_type         rsp_code_ff;
   pos_type          rsp_col_ff, rsp_row_ff;
   logic             rsp_last_ff;

   logic             out_free;
   logic             req_ready;
   logic             accept;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   // configuration writes, clamped on the way in
   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      csr_wide   = SB'(csr_wr_data);
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (csr_wide < SB'(SIZE_MIN)) frame_w_in = WB'(SIZE_MIN);
               else if (csr_wide > SB'(MAX_WIDTH)) frame_w_in = W_MAX;
               else frame_w_in = WB'(csr_wide);
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_wr_data < HB'(SIZE_MIN)) frame_h_in = HB'(SIZE_MIN);
               else if (csr_wr_data > HB'(HEIGHT_MAX)) frame_h_in = HB'(HEIGHT_MAX);
               else frame_h_in = csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= W_RST;
         frame_h_ff <= H_RST;
      end else begin
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
      end
   end

   // position of the incoming pixel; the pre-wrap only fires after a size change
   always_comb begin
      wrap_pre = {1'b0, col_ff} >= frame_w_ff;
      col_cur  = wrap_pre ? '0 : col_ff;
      row_pre  = {1'b0, row_ff} + {{POS_W{1'b0}}, wrap_pre};
      row_cur  = (HB'(row_pre) >= frame_h_ff) ? '0 : row_pre[POS_W-1:0];
      col_inc  = {1'b0, col_cur} + WB'(1);
      row_inc  = {1'b0, row_cur} + (POS_W + 1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_inc >= frame_w_ff) begin
            col_in = '0;
            row_in = (HB'(row_inc) >= frame_h_ff) ? '0 : row_inc[POS_W-1:0];
         end else begin
            col_in = col_inc[CB-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores: read at accept, written back as the word leaves stage 1.
   // Back-to-back words always address different columns, so no forwarding.
   lbp_ram #(
      .WIDTH (MW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({mid_px, s1_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (rd_data)
   );

   assign up_px  = rd_data[MW-1:PIXEL_W];
   assign mid_px = rd_data[PIXEL_W-1:0];

   // stage 1 register
   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_bus.pixel;
         s1_col_ff      <= col_cur;
         s1_row_ff      <= row_cur;
         s1_interior_ff <= (row_cur >= POS_W'(2)) && (col_cur >= CB'(2));
         s1_last_ff     <= ({1'b0, col_cur} == frame_w_ff - WB'(1)) &&
                           (HB'(row_cur) == frame_h_ff - HB'(1));
      end
   end

   // window shift and neighbor compare
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = up_px;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = mid_px;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_pixel_ff;
      code         = '0;
      code[BIT_UL] = win_in[0] >= win_in[4];
      code[BIT_U]  = win_in[1] >= win_in[4];
      code[BIT_UR] = win_in[2] >= win_in[4];
      code[BIT_R]  = win_in[5] >= win_in[4];
      code[BIT_LR] = win_in[8] >= win_in[4];
      code[BIT_D]  = win_in[7] >= win_in[4];
      code[BIT_LL] = win_in[6] >= win_in[4];
      code[BIT_L]  = win_in[3] >= win_in[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // output register
   assign rsp_valid_in = out_free ? (s1_adv && s1_interior_ff) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_interior_ff) begin
         rsp_code_ff <= code;
         rsp_col_ff  <= POS_W'(s1_col_ff - CB'(1));
         rsp_row_ff  <= s1_row_ff - POS_W'(1);
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.lbp_code   = rsp_code_ff;
   assign rsp_bus.center_col = rsp_col_ff;
   assign rsp_bus.center_row = rsp_row_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

endmodule

>>> sv/lbp_checker.sv
// Port-level assertions for the LBP 3x3 pixel stream, bound to the top level
`include "lbp_3x3_pixel_stream_assert.svh"

module lbp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input lbp_pkg::code_type     lbp_code,
   input lbp_pkg::pos_type      center_col,
   input lbp_pkg::pos_type      center_row,
   input logic                  frame_last
);
   import lbp_pkg::*;

   // whole response payload, for the hold check
   logic [CODE_W+2*POS_W:0] rsp_payload;

   assign rsp_payload = {lbp_code, center_col, center_row, frame_last};

   // a stalled response word holds its payload
   `LBP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // reset leaves no response pending
   `LBP_ASSERT_RST(a_rst_empty, reset, !rsp_valid)

   // an empty output register never blocks the input
   `LBP_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready)

   // a code centre is never on the first row or column
   `LBP_ASSERT_IMP(a_interior, rsp_valid, (center_col != '0) && (center_row != '0))

endmodule

bind lbp_3x3_pixel_stream lbp_checker u_lbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .lbp_code   (rsp_bus.lbp_code),
   .center_col (rsp_bus.center_col),
   .center_row (rsp_bus.center_row),
   .frame_last (rsp_bus.frame_last)
);
